### src/ptd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime generator shared definitions
// Widths, limits and the divider status type used across the design.
// ----------------------------------------------------------------------------
package ptd_pkg;

	localparam int MAX_LIMIT     = 65536;
	localparam int DIVISOR_DEPTH = 64;

	localparam int LIMIT_W = 17;
	localparam int PRIME_W = 16;
	localparam int CAND_W  = $clog2(MAX_LIMIT + 2);
	localparam int IDX_W   = $clog2(DIVISOR_DEPTH);
	localparam int CNT_W   = $clog2(DIVISOR_DEPTH) + 1;
	localparam int STEP_W  = $clog2(CAND_W + 1);

	localparam int FIRST_PRIME  = 2;
	localparam int SECOND_PRIME = 3;
	localparam int FIRST_CAND   = 5;
	localparam int CAND_STEP    = 2;
	localparam int LIMIT_RESET  = 1000;

	typedef struct packed {
		logic done;
		logic rem_zero;
		logic quot_below;
	} div_status_t;

endpackage

### src/ptd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/ptd_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Produces one quotient bit per cycle; reports a zero remainder and whether
// the quotient is below the divisor, which means divisor squared exceeds
// the dividend.
// ----------------------------------------------------------------------------
module ptd_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ptd_pkg::CAND_W-1:0]  dividend,
	input  logic [ptd_pkg::PRIME_W-1:0] divisor,
	output ptd_pkg::div_status_t        status
);
	import ptd_pkg::*;

	logic [PRIME_W-1:0] divisor_q;
	logic [PRIME_W-1:0] rem_q;
	logic [CAND_W-1:0]  quot_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;

	logic [PRIME_W:0]   partial;
	logic [PRIME_W:0]   diff;
	logic               fits;

	assign partial = {rem_q, quot_q[CAND_W-1]};
	assign diff    = partial - {1'b0, divisor_q};
	assign fits    = partial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(CAND_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			rem_q     <= '0;
			quot_q    <= dividend;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[PRIME_W-1:0] : partial[PRIME_W-1:0];
			quot_q <= {quot_q[CAND_W-2:0], fits};
		end
	end

	always_comb begin
		status.done       = done_q;
		status.rem_zero   = (rem_q == '0);
		status.quot_below = (quot_q < CAND_W'(divisor_q));
	end

endmodule

### src/prime_generator_trial_division_top.sv
`timescale 1ns / 1ps
// Two and three are answered directly from the request; a search steps through odd candidates,
// reading each stored prime from the registered prime table and testing it with the
// bit-serial divider.
// Throughput: one request at a time; the next is taken once a result is out.
// Reset: limit 1000, sequence restarts at two, prime table count zero.
// ----------------------------------------------------------------------------
// Trial-division prime generator top level
// Returns the next prime for every request: two and three first, then primes below the configured
// limit, or a not-found result once they run out.
module prime_generator_trial_division_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        upper_limit_we,
	input  logic [ptd_pkg::LIMIT_W-1:0] upper_limit_wdata,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        restart,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [ptd_pkg::PRIME_W-1:0] prime_value,
	output logic                        found
);
	import ptd_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CAND   = 3'd1;
	localparam logic [2:0] ST_NEXT   = 3'd2;
	localparam logic [2:0] ST_RDWAIT = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_PASS   = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	localparam logic [1:0] PH_TWO    = 2'd0;
	localparam logic [1:0] PH_THREE  = 2'd1;
	localparam logic [1:0] PH_SEARCH = 2'd2;

	logic [2:0]         state_q;
	logic [1:0]         lead_phase_q;
	logic [LIMIT_W-1:0] upper_limit_q;
	logic [CAND_W-1:0]  candidate_q;
	logic [CAND_W-1:0]  n_q;
	logic [CNT_W-1:0]   stored_count_q;
	logic [CNT_W-1:0]   idx_q;
	logic [PRIME_W-1:0] res_value_q;
	logic               res_found_q;
	logic               rsp_valid_q;
	logic [PRIME_W-1:0] prime_value_q;
	logic               found_q;

	logic [LIMIT_W-1:0] limit_eff;
	logic               req_accept;
	logic               out_free;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [PRIME_W-1:0] ram_wdata;
	logic               ram_re;
	logic [PRIME_W-1:0] ram_rdata;
	logic               div_start;
	div_status_t        div_status;
	logic               table_room;

	assign limit_eff  = (upper_limit_q > LIMIT_W'(MAX_LIMIT)) ? LIMIT_W'(MAX_LIMIT)
	                                                          : upper_limit_q;
	assign req_stall  = (state_q != ST_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign table_room = stored_count_q < CNT_W'(DIVISOR_DEPTH);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = stored_count_q[IDX_W-1:0];
		ram_wdata = n_q[PRIME_W-1:0];
		if (req_accept && !restart && lead_phase_q == PH_THREE) begin
			ram_we    = table_room;
			ram_wdata = PRIME_W'(SECOND_PRIME);
		end else if (state_q == ST_PASS) begin
			ram_we = table_room;
		end
	end

	assign ram_re    = (state_q == ST_NEXT) && (idx_q != stored_count_q);
	assign div_start = (state_q == ST_RDWAIT) && (ram_rdata != '0);

	ptd_ram #(
		.WIDTH(PRIME_W),
		.DEPTH(DIVISOR_DEPTH)
	) u_prime_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	ptd_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(n_q),
		.divisor (ram_rdata),
		.status  (div_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			lead_phase_q   <= PH_TWO;
			upper_limit_q  <= LIMIT_W'(LIMIT_RESET);
			candidate_q    <= CAND_W'(FIRST_CAND);
			stored_count_q <= '0;
			idx_q          <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (upper_limit_we) begin
				upper_limit_q <= upper_limit_wdata;
			end
			if (state_q == ST_EMIT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_accept) begin
						if (restart || lead_phase_q == PH_TWO) begin
							lead_phase_q   <= PH_THREE;
							candidate_q    <= CAND_W'(FIRST_CAND);
							stored_count_q <= restart ? '0 : stored_count_q;
							state_q        <= ST_EMIT;
						end else if (lead_phase_q == PH_THREE) begin
							lead_phase_q <= PH_SEARCH;
							if (table_room) begin
								stored_count_q <= stored_count_q + 1'b1;
							end
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_CAND;
						end
					end
				end
				ST_CAND: begin
					if (candidate_q < limit_eff) begin
						candidate_q <= candidate_q + CAND_W'(CAND_STEP);
						idx_q       <= '0;
						state_q     <= ST_NEXT;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_NEXT: begin
					state_q <= (idx_q == stored_count_q) ? ST_PASS : ST_RDWAIT;
				end
				ST_RDWAIT: begin
					state_q <= (ram_rdata == '0) ? ST_PASS : ST_DIV;
				end
				ST_DIV: begin
					if (div_status.done) begin
						if (div_status.quot_below) begin
							state_q <= ST_PASS;
						end else if (div_status.rem_zero) begin
							state_q <= ST_CAND;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_NEXT;
						end
					end
				end
				ST_PASS: begin
					if (table_room) begin
						stored_count_q <= stored_count_q + 1'b1;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_accept) begin
					res_found_q <= 1'b1;
					if (restart || lead_phase_q == PH_TWO) begin
						res_value_q <= PRIME_W'(FIRST_PRIME);
					end else begin
						res_value_q <= PRIME_W'(SECOND_PRIME);
					end
				end
			end
			ST_CAND: begin
				n_q         <= candidate_q;
				res_value_q <= '0;
				res_found_q <= 1'b0;
			end
			ST_PASS: begin
				res_value_q <= n_q[PRIME_W-1:0];
				res_found_q <= 1'b1;
			end
			ST_EMIT: begin
				if (out_free) begin
					prime_value_q <= res_value_q;
					found_q       <= res_found_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid   = rsp_valid_q;
	assign prime_value = prime_value_q;
	assign found       = found_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		stored_count_q <= CNT_W'(DIVISOR_DEPTH))
		else $error("prime table count exceeds its depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		candidate_q[0] == 1'b1)
		else $error("candidate is even");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && found |-> prime_value != '0)
		else $error("found result carries a zero value");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> prime_value == '0)
		else $error("exhausted result carries a nonzero value");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> n_q < candidate_q)
		else $error("divider started on a stale candidate");
`endif

endmodule
